>>> src/uds_pkg.sv
package uds_pkg;

  localparam int unsigned CpW          = 21;
  localparam int unsigned CntW         = 3;
  localparam int unsigned QueueDepthDef = 2;

  localparam logic [CpW-1:0] CpMax     = 21'h10FFFF;
  localparam logic [CpW-1:0] SurLo     = 21'h00D800;
  localparam logic [CpW-1:0] SurHi     = 21'h00DFFF;
  localparam logic [CpW-1:0] ReplReset = 21'h00FFFD;

  typedef enum logic [2:0] {
    LeadAscii = 3'd0,
    LeadTwo   = 3'd1,
    LeadThree = 3'd2,
    LeadFour  = 3'd3,
    LeadBad   = 3'd4
  } uds_lead_e;

  // One queue entry: how many results a byte causes, and an optional
  // decoded value that always goes out as the final result.
  typedef struct packed {
    logic [CntW-1:0] cnt;
    logic            has_value;
    logic [CpW-1:0]  value;
  } uds_rec_t;

  function automatic uds_lead_e lead_class(input logic [7:0] b);
    uds_lead_e k;
    if (b[7] == 1'b0) begin
      k = LeadAscii;
    end else if (b[7:5] == 3'b110) begin
      k = LeadTwo;
    end else if (b[7:4] == 4'b1110) begin
      k = LeadThree;
    end else if (b[7:3] == 5'b11110) begin
      k = LeadFour;
    end else begin
      k = LeadBad;
    end
    return k;
  endfunction

endpackage

>>> src/utf8_stream_decoder_top.sv
// Channel   Direction  Handshake             Payload
// input     in         push / full           data_byte_i, end_of_text_i
// result    out        empty / pop           codepoint_o, was_replaced_o, last_in_run_o
// config    in         cfg_valid_i / ready   replacement_codepoint_i
//
// One byte per cycle enters the classifier while full is low; a byte yields 0 to 4 results.
// The result side delivers one result per cycle while pop is high, so a byte with n results
// holds the queue head until all n are popped; QueueDepth entries absorb the bursts.
// Results come straight from queue registers; nothing combinational from pop.
// Reset clears the open sequence and the queue, and restores U+FFFD.
module utf8_stream_decoder_top #(
  parameter int unsigned QueueDepth = uds_pkg::QueueDepthDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push,
  output logic                     full,
  input  logic [7:0]               data_byte_i,
  input  logic                     end_of_text_i,
  output logic                     empty,
  input  logic                     pop,
  output logic [uds_pkg::CpW-1:0]  codepoint_o,
  output logic                     was_replaced_o,
  output logic                     last_in_run_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [uds_pkg::CpW-1:0]  replacement_codepoint_i
);
  import uds_pkg::*;

  logic     in_fire;
  logic     rec_valid;
  uds_rec_t rec;
  logic     q_full;
  logic     q_empty;
  uds_rec_t head;
  logic     head_pop;

  assign full        = q_full;
  assign empty       = q_empty;
  assign in_fire     = push && !q_full;
  assign cfg_ready_o = 1'b1;

  uds_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (in_fire),
    .data_byte_i   (data_byte_i),
    .end_of_text_i (end_of_text_i),
    .rec_valid_o   (rec_valid),
    .rec_o         (rec)
  );

  uds_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (rec_valid),
    .wr_data_i (rec),
    .full_o    (q_full),
    .rd_en_i   (head_pop),
    .empty_o   (q_empty),
    .rd_data_o (head)
  );

  uds_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_fire_i     (cfg_valid_i && cfg_ready_o),
    .cfg_data_i     (replacement_codepoint_i),
    .head_valid_i   (!q_empty),
    .head_i         (head),
    .head_pop_o     (head_pop),
    .pop_i          (pop),
    .codepoint_o    (codepoint_o),
    .was_replaced_o (was_replaced_o),
    .last_in_run_o  (last_in_run_o)
  );

endmodule

>>> src/uds_front.sv
module uds_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic [7:0]          data_byte_i,
  input  logic                end_of_text_i,
  output logic                rec_valid_o,
  output uds_pkg::uds_rec_t   rec_o
);
  import uds_pkg::*;

  logic [CpW-1:0] pv_q, pv_d;
  logic [1:0]     exp_q, exp_d;
  logic [1:0]     rcv_q, rcv_d;

  logic           open_seq;
  logic           is_cont;
  logic [1:0]     got;
  logic [CpW-1:0] pv_shift;
  logic [CntW-1:0] flush_cnt;
  uds_lead_e      lead;
  uds_rec_t       rec;

  assign open_seq  = (exp_q != 2'd0);
  assign is_cont   = (data_byte_i[7:6] == 2'b10);
  assign got       = rcv_q + 2'd1;
  assign pv_shift  = {pv_q[CpW-7:0], data_byte_i[5:0]};
  assign flush_cnt = open_seq ? ({1'b0, rcv_q} + 3'd1) : 3'd0;
  assign lead      = lead_class(data_byte_i);

  always_comb begin
    exp_d         = exp_q;
    rcv_d         = rcv_q;
    pv_d          = pv_q;
    rec.cnt       = 3'd0;
    rec.has_value = 1'b0;
    rec.value     = {13'd0, data_byte_i};
    if (open_seq && is_cont) begin
      if (got >= exp_q) begin
        rec.cnt       = 3'd1;
        rec.value     = pv_shift;
        rec.has_value = !(pv_shift > CpMax || (pv_shift >= SurLo && pv_shift <= SurHi));
        exp_d         = 2'd0;
        rcv_d         = 2'd0;
        pv_d          = '0;
      end else if (end_of_text_i) begin
        // truncated at end of text: lead plus every buffered continuation
        rec.cnt = {1'b0, got} + 3'd1;
        exp_d   = 2'd0;
        rcv_d   = 2'd0;
        pv_d    = '0;
      end else begin
        rcv_d = got;
        pv_d  = pv_shift;
      end
    end else begin
      // flush any open sequence, then treat the byte as a new lead
      rec.cnt = flush_cnt;
      exp_d   = 2'd0;
      rcv_d   = 2'd0;
      pv_d    = '0;
      unique case (lead)
        LeadAscii: begin
          rec.cnt       = flush_cnt + 3'd1;
          rec.has_value = 1'b1;
        end
        LeadTwo, LeadThree, LeadFour: begin
          if (end_of_text_i) begin
            rec.cnt = flush_cnt + 3'd1;
          end else begin
            unique case (lead)
              LeadTwo: begin
                exp_d = 2'd1;
                pv_d  = {16'd0, data_byte_i[4:0]};
              end
              LeadThree: begin
                exp_d = 2'd2;
                pv_d  = {17'd0, data_byte_i[3:0]};
              end
              default: begin
                exp_d = 2'd3;
                pv_d  = {18'd0, data_byte_i[2:0]};
              end
            endcase
          end
        end
        default: begin
          rec.cnt = flush_cnt + 3'd1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q <= 2'd0;
      rcv_q <= 2'd0;
      pv_q  <= '0;
    end else if (fire_i) begin
      exp_q <= exp_d;
      rcv_q <= rcv_d;
      pv_q  <= pv_d;
    end
  end

  assign rec_valid_o = fire_i && (rec.cnt != 3'd0);
  assign rec_o       = rec;

  a_rcv_below_exp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exp_q == 2'd0 && rcv_q == 2'd0) || (rcv_q < exp_q))
    else $error("received count not below expected count");

  a_rec_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_valid_o |-> (rec_o.cnt <= 3'd4))
    else $error("more than four results for one byte");

endmodule

>>> src/uds_queue.sv
module uds_queue #(
  parameter int unsigned Depth = uds_pkg::QueueDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  uds_pkg::uds_rec_t  wr_data_i,
  output logic               full_o,
  input  logic               rd_en_i,
  output logic               empty_o,
  output uds_pkg::uds_rec_t  rd_data_o
);
  import uds_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntQW = $clog2(Depth + 1);

  uds_rec_t          mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntQW-1:0]  count_q, count_d;
  logic              do_wr, do_rd;

  assign full_o    = (count_q == CntQW'(Depth));
  assign empty_o   = (count_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_i |-> !full_o)
    else $error("write into full queue");

endmodule

>>> src/uds_back.sv
module uds_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_fire_i,
  input  logic [uds_pkg::CpW-1:0]   cfg_data_i,
  input  logic                      head_valid_i,
  input  uds_pkg::uds_rec_t         head_i,
  output logic                      head_pop_o,
  input  logic                      pop_i,
  output logic [uds_pkg::CpW-1:0]   codepoint_o,
  output logic                      was_replaced_o,
  output logic                      last_in_run_o
);
  import uds_pkg::*;

  logic [CpW-1:0] repl_q;
  logic [1:0]     idx_q, idx_d;
  logic           last;
  logic           fire;

  assign last  = ({1'b0, idx_q} == (head_i.cnt - 3'd1));
  assign fire  = pop_i && head_valid_i;

  assign head_pop_o     = fire && last;
  assign last_in_run_o  = last;
  assign was_replaced_o = !(last && head_i.has_value);
  assign codepoint_o    = (last && head_i.has_value) ? head_i.value : repl_q;

  always_comb begin
    idx_d = idx_q;
    if (fire) begin
      idx_d = last ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repl_q <= ReplReset;
      idx_q  <= 2'd0;
    end else begin
      if (cfg_fire_i) begin
        repl_q <= cfg_data_i;
      end
      idx_q <= idx_d;
    end
  end

  a_idx_in_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> ({1'b0, idx_q} < head_i.cnt))
    else $error("result index past entry count");

  a_idx_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !head_valid_i |-> (idx_q == 2'd0))
    else $error("result index nonzero with no entry");

endmodule

>>> tb/sv/utf8_stream_decoder_top_tb.sv
module utf8_stream_decoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import uds_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       eot;
  } text_byte_t;

  typedef struct packed {
    logic [CpW-1:0] cp;
    logic           repl;
    logic           last;
  } cp_result_t;

  typedef enum logic [1:0] {
    PopAlways  = 2'd0,
    PopCoin    = 2'd1,
    PopPattern = 2'd2
  } pop_style_e;

  logic           clk_i                   = 1'b0;
  logic           rst_ni                  = 1'b0;
  logic           push                    = 1'b0;
  logic           full;
  logic [7:0]     data_byte_i             = '0;
  logic           end_of_text_i           = 1'b0;
  logic           empty;
  logic           pop                     = 1'b0;
  logic [CpW-1:0] codepoint_o;
  logic           was_replaced_o;
  logic           last_in_run_o;
  logic           cfg_valid_i             = 1'b0;
  logic           cfg_ready_o;
  logic [CpW-1:0] replacement_codepoint_i = '0;

  // decoder shadow state
  logic [CpW-1:0] repl_cp   = ReplReset;
  logic [CpW-1:0] acc_value = '0;
  logic [1:0]     cont_need = '0;
  logic [1:0]     cont_got  = '0;

  text_byte_t  pending_bytes[$];
  cp_result_t  awaited_cps[$];
  int unsigned err_cnt = 0;

  utf8_stream_decoder_top DUT (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .push                    (push),
    .full                    (full),
    .data_byte_i             (data_byte_i),
    .end_of_text_i           (end_of_text_i),
    .empty                   (empty),
    .pop                     (pop),
    .codepoint_o             (codepoint_o),
    .was_replaced_o          (was_replaced_o),
    .last_in_run_o           (last_in_run_o),
    .cfg_valid_i             (cfg_valid_i),
    .cfg_ready_o             (cfg_ready_o),
    .replacement_codepoint_i (replacement_codepoint_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("tb: failure");
    $finish;
  end

  function automatic void post_cp(input logic [CpW-1:0] cp, input logic repl);
    cp_result_t r;
    r.cp   = cp;
    r.repl = repl;
    r.last = 1'b0;
    awaited_cps.push_back(r);
  endfunction

  function automatic void close_seq();
    acc_value = '0;
    cont_need = '0;
    cont_got  = '0;
  endfunction

  // one replacement for the lead, one per buffered continuation
  function automatic void flush_open();
    post_cp(repl_cp, 1'b1);
    for (int k = 0; k < int'(cont_got) && k < 2; k++) post_cp(repl_cp, 1'b1);
    close_seq();
  endfunction

  function automatic uds_lead_e classify(input logic [7:0] b);
    uds_lead_e k;
    casez (b)
      8'b0???????: k = LeadAscii;
      8'b110?????: k = LeadTwo;
      8'b1110????: k = LeadThree;
      8'b11110???: k = LeadFour;
      default:     k = LeadBad;
    endcase
    return k;
  endfunction

  function automatic void open_or_emit(input logic [7:0] b);
    case (classify(b))
      LeadAscii: post_cp({13'd0, b}, 1'b0);
      LeadTwo: begin
        cont_need = 2'd1;
        cont_got  = '0;
        acc_value = {16'd0, b[4:0]};
      end
      LeadThree: begin
        cont_need = 2'd2;
        cont_got  = '0;
        acc_value = {17'd0, b[3:0]};
      end
      LeadFour: begin
        cont_need = 2'd3;
        cont_got  = '0;
        acc_value = {18'd0, b[2:0]};
      end
      default: post_cp(repl_cp, 1'b1);
    endcase
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic eot);
    int unsigned n0;
    n0 = awaited_cps.size();
    if (cont_need != '0) begin
      if (b[7:6] == 2'b10) begin
        acc_value = {acc_value[CpW-7:0], b[5:0]};
        if (int'(cont_got) + 1 >= int'(cont_need)) begin
          if (acc_value > CpMax || (acc_value >= SurLo && acc_value <= SurHi)) begin
            post_cp(repl_cp, 1'b1);
          end else begin
            post_cp(acc_value, 1'b0);
          end
          close_seq();
        end else begin
          cont_got = cont_got + 2'd1;
        end
      end else begin
        flush_open();
        open_or_emit(b);
      end
    end else begin
      open_or_emit(b);
    end
    if (eot && cont_need != '0) flush_open();
    if (awaited_cps.size() > n0) awaited_cps[awaited_cps.size()-1].last = 1'b1;
  endfunction

  // byte sender: bursts of random length, random gaps between them
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin : drive_p
    logic nxt_push;
    if (!rst_ni) begin
      push          <= 1'b0;
      data_byte_i   <= '0;
      end_of_text_i <= 1'b0;
    end else begin
      if (push && !full) begin
        pending_bytes.delete(0);
        decode_byte(data_byte_i, end_of_text_i);
      end
      nxt_push = 1'b0;
      if (push && full) begin
        nxt_push = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (pending_bytes.size() > 0) begin
        nxt_push = 1'b1;
        data_byte_i   <= pending_bytes[0].data;
        end_of_text_i <= pending_bytes[0].eot;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(1, 8);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      push <= nxt_push;
    end
  end

  // result receiver: checks each transaction, stalls on its own pattern
  pop_style_e  pop_style = PopAlways;
  int unsigned style_left = 0;
  logic [7:0]  pop_pat    = 8'hff;

  always @(posedge clk_i or negedge rst_ni) begin : watch_p
    cp_result_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (awaited_cps.size() == 0) begin
          $display("%0t: unexpected result cp=%h repl=%b last=%b", $time,
                   codepoint_o, was_replaced_o, last_in_run_o);
          err_cnt++;
        end else begin
          want = awaited_cps.pop_front();
          if (codepoint_o !== want.cp) begin
            $display("%0t: codepoint expected %h actual %h", $time, want.cp, codepoint_o);
            err_cnt++;
          end
          if (was_replaced_o !== want.repl) begin
            $display("%0t: was_replaced expected %b actual %b", $time, want.repl,
                     was_replaced_o);
            err_cnt++;
          end
          if (last_in_run_o !== want.last) begin
            $display("%0t: last_in_run expected %b actual %b", $time, want.last,
                     last_in_run_o);
            err_cnt++;
          end
        end
      end
      if (style_left == 0) begin
        pop_style  = pop_style_e'($urandom_range(0, 2));
        style_left = $urandom_range(16, 80);
        pop_pat    = 8'($urandom) | 8'h01;
      end else begin
        style_left--;
      end
      pop_pat = {pop_pat[6:0], pop_pat[7]};
      case (pop_style)
        PopAlways: pop <= 1'b1;
        PopCoin:   pop <= 1'($urandom_range(0, 1));
        default:   pop <= pop_pat[0];
      endcase
    end
  end

  task automatic add_byte(input logic [7:0] b, input logic eot);
    text_byte_t t;
    t.data = b;
    t.eot  = eot;
    pending_bytes.push_back(t);
  endtask

  // mostly well-formed sequences with random payload, some cut short, some noise
  task automatic add_random(input int unsigned count);
    int unsigned made;
    int unsigned kind;
    int unsigned len;
    logic [7:0]  b;
    made = 0;
    while (made < count) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        len = $urandom_range(1, 4);
        case (len)
          1:       b = 8'($urandom_range(0, 8'h7f));
          2:       b = 8'hc0 | 8'($urandom_range(0, 8'h1f));
          3:       b = 8'he0 | 8'($urandom_range(0, 8'h0f));
          default: b = 8'hf0 | 8'($urandom_range(0, 8'h07));
        endcase
        if (kind == 6) len = $urandom_range(1, len);
        add_byte(b, $urandom_range(0, 9) == 0);
        for (int i = 1; i < int'(len); i++) begin
          add_byte(8'h80 | 8'($urandom_range(0, 8'h3f)), $urandom_range(0, 9) == 0);
        end
        made += len;
      end else begin
        add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
        made++;
      end
    end
  endtask

  // stimulus holds off until every queued byte is taken and every result is back
  task automatic wait_drained();
    while (pending_bytes.size() != 0 || push || awaited_cps.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_repl(input logic [CpW-1:0] v);
    @(posedge clk_i);
    cfg_valid_i             <= 1'b1;
    replacement_codepoint_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    repl_cp = v;
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : stim_p
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_byte(8'h00, 1'b0);
    add_byte(8'h7f, 1'b0);
    add_byte(8'hc2, 1'b0); add_byte(8'ha9, 1'b0);
    add_byte(8'he2, 1'b0); add_byte(8'h82, 1'b0); add_byte(8'hac, 1'b0);
    add_byte(8'hf0, 1'b0); add_byte(8'h9f, 1'b0); add_byte(8'h98, 1'b0);
    add_byte(8'h80, 1'b0);
    // largest 4-byte payload, beyond the code space
    add_byte(8'hf7, 1'b0); add_byte(8'hbf, 1'b0); add_byte(8'hbf, 1'b0);
    add_byte(8'hbf, 1'b0);
    // surrogate
    add_byte(8'hed, 1'b0); add_byte(8'ha0, 1'b0); add_byte(8'h80, 1'b0);
    // stray continuation, then a byte that can never lead
    add_byte(8'h80, 1'b0);
    add_byte(8'hff, 1'b1);
    // two buffered continuations broken by ASCII: four results
    add_byte(8'hf0, 1'b0); add_byte(8'h90, 1'b0); add_byte(8'h80, 1'b0);
    add_byte(8'h41, 1'b0);
    // end of text inside an open sequence
    add_byte(8'hf4, 1'b0); add_byte(8'h8f, 1'b1);
    add_byte(8'he0, 1'b1);
    wait_drained();

    write_repl(CpMax);
    add_random(23);
    wait_drained();

    write_repl('0);
    add_random(23);
    wait_drained();

    write_repl(CpW'($urandom_range(0, 32'h10ffff)));
    add_random(23);
    wait_drained();

    write_repl(CpW'($urandom_range(0, 32'h10ffff)));
    add_random(23);
    wait_drained();
    repeat (20) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
